[rtl/lvagc_pkg.sv]
// Shared types, fixed-point constants and the shift helper for the LMS voice AGC.
// Used by lms_voice_agc; depends on nothing else.
`default_nettype none

package lvagc_pkg;

   typedef logic [63:0] word_type;

   localparam int unsigned SMOOTH_SHIFT = 15;
   localparam int unsigned STEP_SHIFT   = 30;
   localparam int unsigned GAIN_SHIFT   = 15;
   localparam int unsigned GSHIFT       = 60 - STEP_SHIFT;
   localparam int unsigned Y_SHIFT      = (GAIN_SHIFT + GSHIFT > 63) ? 63 : GAIN_SHIFT + GSHIFT;
   localparam int unsigned OP_SHIFT     = 2 * GAIN_SHIFT;

   localparam int unsigned DIGIT_BITS   = 4;

   localparam word_type    UNITY_GAIN   = 64'd32768;
   localparam logic [16:0] BIG_LEVEL    = 17'd1024;
   localparam logic [16:0] SMALL_LEVEL  = 17'd16;

   // Arithmetic right shift of a 64-bit two's complement word by a fixed amount.
   function automatic word_type asr(word_type v, int unsigned s);
      word_type r;
      r = word_type'($signed(v) >>> s);
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/lms_voice_agc.sv]
// LMS automatic gain control for 16-bit audio, built around one digit-serial multiplier.
// Depends on lvagc_pkg for the word type, shift constants and the shift helper.
//
//   channel | direction | handshake                   | payload
//   req     | in        | req_tvalid / req_tready     | req_tdata[15:0] = sample_in
//   rsp     | out       | rsp_tvalid / rsp_tready     | rsp_tdata[15:0] = sample_out
//   csr     | in        | csr_wr_en (no wait)         | csr_index, csr_wdata
//
// Every product goes through one 64-bit shift-and-add multiplier that takes a 4-bit digit of
// its multiplier operand per cycle and stops once the remaining digits are zero. The first
// item after reset needs one product; every later item needs nine products and the clamp
// states CLAMP_LO and CLAMP_HI. Reset is synchronous and clears the state, the flags, the
// ip, op and gain registers and the CSRs; the other datapath registers are not reset. The
// block takes a new item while the previous result still waits in the output register; it
// holds its final step until that register is free.
`default_nettype none

module lms_voice_agc (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // [15:0] sample_in
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] sample_out
   input  wire         csr_wr_en,
   input  wire  [2:0]  csr_index,
   input  wire  [31:0] csr_wdata
);

   localparam logic [1:0] ST_IDLE     = 2'd0;
   localparam logic [1:0] ST_MUL      = 2'd1;
   localparam logic [1:0] ST_CLAMP_LO = 2'd2;
   localparam logic [1:0] ST_CLAMP_HI = 2'd3;

   localparam logic [3:0] P_XX   = 4'd0;
   localparam logic [3:0] P_CIP  = 4'd1;
   localparam logic [3:0] P_PX   = 4'd2;
   localparam logic [3:0] P_MU   = 4'd3;
   localparam logic [3:0] P_ERR  = 4'd4;
   localparam logic [3:0] P_GAIN = 4'd5;
   localparam logic [3:0] P_Y    = 4'd6;
   localparam logic [3:0] P_GG   = 4'd7;
   localparam logic [3:0] P_OP   = 4'd8;

   localparam logic [2:0] R_GOAL   = 3'd0;
   localparam logic [2:0] R_LARGE  = 3'd1;
   localparam logic [2:0] R_MID    = 3'd2;
   localparam logic [2:0] R_SMALL  = 3'd3;
   localparam logic [2:0] R_SMOOTH = 3'd4;
   localparam logic [2:0] R_FLOOR  = 3'd5;
   localparam logic [2:0] R_CEIL   = 3'd6;

   logic [31:0] goal_ff, floor_ff, ceil_ff;
   logic [14:0] large_ff, mid_ff, small_ff;
   logic [16:0] smooth_ff;

   logic [1:0]  state_ff, state_in;
   logic [3:0]  phase_ff, phase_in;
   lvagc_pkg::word_type acc_ff, acc_in, a_ff, a_in, b_ff, b_in;
   lvagc_pkg::word_type xx_ff, xx_in, px_ff, px_in, ip_ff, ip_in, op_ff, op_in;
   lvagc_pkg::word_type gain_ff, gain_in, gnew_ff, gnew_in;
   logic [15:0] x_ff, x_in, y_ff, y_in, rsp_data_ff, rsp_data_in;
   logic        seeded_ff, seeded_in, rsp_valid_ff, rsp_valid_in;

   lvagc_pkg::word_type partial, x_ext, px_new, g_clamp, floor_w, ceil_w, y_full;
   logic [16:0] mag;
   logic [14:0] mu;
   logic        mul_done, out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      partial = '0;
      for (int i = 0; i < lvagc_pkg::DIGIT_BITS; i++) begin
         if (b_ff[i]) begin
            partial = partial + (a_ff << i);
         end
      end
   end

   always_comb begin
      mul_done = (b_ff == '0);
      out_free = !rsp_valid_ff || rsp_tready;
      x_ext    = {{48{x_ff[15]}}, x_ff};
      mag      = x_ff[15] ? (17'd0 - {1'b1, x_ff}) : {1'b0, x_ff};
      if (mag > lvagc_pkg::BIG_LEVEL) begin
         mu = large_ff;
      end else if (mag < lvagc_pkg::SMALL_LEVEL) begin
         mu = small_ff;
      end else begin
         mu = mid_ff;
      end
      px_new  = lvagc_pkg::asr(acc_ff, lvagc_pkg::SMOOTH_SHIFT);
      y_full  = lvagc_pkg::asr(acc_ff, lvagc_pkg::Y_SHIFT);
      floor_w = {32'd0, floor_ff};
      ceil_w  = {32'd0, ceil_ff};
      g_clamp = ($signed(ceil_w) < $signed(gnew_ff)) ? ceil_w : gnew_ff;
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      acc_in       = acc_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      xx_in        = xx_ff;
      px_in        = px_ff;
      ip_in        = ip_ff;
      op_in        = op_ff;
      gain_in      = gain_ff;
      gnew_in      = gnew_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      seeded_in    = seeded_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               x_in     = req_tdata;
               a_in     = {{48{req_tdata[15]}}, req_tdata};
               b_in     = {{48{req_tdata[15]}}, req_tdata};
               acc_in   = '0;
               phase_in = P_XX;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (!mul_done) begin
               acc_in = acc_ff + partial;
               a_in   = a_ff << lvagc_pkg::DIGIT_BITS;
               b_in   = b_ff >> lvagc_pkg::DIGIT_BITS;
            end else begin
               unique case (phase_ff)
                  P_XX: begin
                     xx_in = acc_ff;
                     if (!seeded_ff) begin
                        if (out_free) begin
                           ip_in        = acc_ff;
                           op_in        = acc_ff;
                           gain_in      = lvagc_pkg::UNITY_GAIN;
                           seeded_in    = 1'b1;
                           rsp_valid_in = 1'b1;
                           rsp_data_in  = x_ff;
                           state_in     = ST_IDLE;
                        end
                     end else begin
                        a_in     = {47'd0, smooth_ff};
                        b_in     = ip_ff;
                        acc_in   = '0;
                        phase_in = P_CIP;
                     end
                  end
                  P_CIP: begin
                     // The first product stays in the accumulator as the addend.
                     a_in     = (64'd1 << lvagc_pkg::SMOOTH_SHIFT) - {47'd0, smooth_ff};
                     b_in     = xx_ff;
                     phase_in = P_PX;
                  end
                  P_PX: begin
                     px_in    = px_new;
                     a_in     = {49'd0, mu};
                     b_in     = px_new;
                     acc_in   = '0;
                     phase_in = P_MU;
                  end
                  P_MU: begin
                     a_in     = acc_ff;
                     b_in     = {32'd0, goal_ff} - op_ff;
                     acc_in   = '0;
                     phase_in = P_ERR;
                  end
                  P_ERR: begin
                     a_in     = gain_ff;
                     b_in     = (64'd1 << lvagc_pkg::GSHIFT)
                              + lvagc_pkg::asr(acc_ff, lvagc_pkg::STEP_SHIFT);
                     acc_in   = '0;
                     phase_in = P_GAIN;
                  end
                  P_GAIN: begin
                     gnew_in  = lvagc_pkg::asr(acc_ff, lvagc_pkg::GSHIFT);
                     a_in     = acc_ff;
                     b_in     = x_ext;
                     acc_in   = '0;
                     phase_in = P_Y;
                  end
                  P_Y: begin
                     y_in     = y_full[15:0];
                     state_in = ST_CLAMP_LO;
                  end
                  P_GG: begin
                     a_in     = acc_ff;
                     b_in     = px_ff;
                     acc_in   = '0;
                     phase_in = P_OP;
                  end
                  P_OP: begin
                     if (out_free) begin
                        op_in        = lvagc_pkg::asr(acc_ff, lvagc_pkg::OP_SHIFT);
                        ip_in        = px_ff;
                        gain_in      = gnew_ff;
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = y_ff;
                        state_in     = ST_IDLE;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CLAMP_LO: begin
            if ($signed(gnew_ff) < $signed(floor_w)) begin
               gnew_in = floor_w;
            end
            state_in = ST_CLAMP_HI;
         end
         ST_CLAMP_HI: begin
            gnew_in  = g_clamp;
            a_in     = g_clamp;
            b_in     = g_clamp;
            acc_in   = '0;
            phase_in = P_GG;
            state_in = ST_MUL;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= P_XX;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ip_ff        <= '0;
         op_ff        <= '0;
         gain_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
         ip_ff        <= ip_in;
         op_ff        <= op_in;
         gain_ff      <= gain_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      xx_ff       <= xx_in;
      px_ff       <= px_in;
      gnew_ff     <= gnew_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_ff   <= 32'd0;
         large_ff  <= 15'd1;
         mid_ff    <= 15'd1;
         small_ff  <= 15'd1;
         smooth_ff <= 17'd31130;
         floor_ff  <= 32'd1024;
         ceil_ff   <= 32'd1048576;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            R_GOAL:   goal_ff   <= csr_wdata;
            R_LARGE:  large_ff  <= csr_wdata[14:0];
            R_MID:    mid_ff    <= csr_wdata[14:0];
            R_SMALL:  small_ff  <= csr_wdata[14:0];
            R_SMOOTH: smooth_ff <= csr_wdata[16:0];
            R_FLOOR:  floor_ff  <= csr_wdata;
            R_CEIL:   ceil_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire
